@@ rtl/core/edf_pkg.sv @@
// edf_pkg: shared types and constants of the edf tick scheduler
// command codes, field widths, controller to datapath command and status structs
// no dependencies
package edf_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 3;
    localparam int VAL_W  = 16;
    localparam int ACT_W  = 4;
    localparam int TICK_W = 32;
    localparam int BL_W   = 8;

    localparam logic [BL_W-1:0] BL_MAX = 8'd255;
    localparam logic [ACT_W-1:0] ACTIVE_RST = 4'd1;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_LOAD    = 2'd0;
    localparam t_cmd CMD_RESTART = 2'd1;
    localparam t_cmd CMD_TICK    = 2'd2;

    typedef struct packed {
        logic capture;
        logic start;
        logic load;
        logic restart;
        logic scan;
        logic apply;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd item_cmd;
    } t_dp_stat;

endpackage

@@ rtl/core/edf_ctrl.sv @@
// edf_ctrl: sequencing state machine of the edf tick scheduler
// owns the handshakes, the active slot count and the slot scan counter
// depends on edf_pkg
module edf_ctrl
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic [ACT_W-1:0]    i_cfg_data,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd,
    output logic [(TASK_SLOTS > 1 ? $clog2(TASK_SLOTS) : 1)-1:0] o_idx
);

    localparam int IW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNW = $clog2(TASK_SLOTS + 1);
    localparam int CW  = (CNW > ACT_W) ? CNW : ACT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPLY,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [IW-1:0]     r_idx;
    logic [ACT_W-1:0]  r_active;
    logic              r_out_valid;

    logic [CW-1:0]     w_active_ext;
    logic [CW-1:0]     w_count;
    logic              w_last;
    t_dp_cmd           w_cmd;

    always_comb begin
        w_active_ext = CW'(r_active);
        w_count = (w_active_ext > CW'(TASK_SLOTS)) ? CW'(TASK_SLOTS) : w_active_ext;
        w_last = ((CW'(r_idx) + CW'(1)) == w_count);

        w_cmd = '0;
        w_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        w_cmd.start   = (r_state == S_DECODE);
        w_cmd.load    = (r_state == S_DECODE) && (i_stat.item_cmd == CMD_LOAD);
        w_cmd.restart = (r_state == S_DECODE) && (i_stat.item_cmd == CMD_RESTART);
        w_cmd.scan    = (r_state == S_SCAN);
        w_cmd.apply   = (r_state == S_APPLY);
        w_cmd.publish = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_active    <= ACTIVE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            if (w_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx <= '0;
                    if (i_stat.item_cmd == CMD_TICK) begin
                        r_state <= (w_count == '0) ? S_APPLY : S_SCAN;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_APPLY: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_cmd.publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;
    assign o_idx       = r_idx;

endmodule

@@ rtl/core/edf_dpath.sv @@
// edf_dpath: task tables, release and earliest-deadline scan, result register
// one slot is examined per scan command, the picked slot is updated on apply
// depends on edf_pkg
module edf_dpath
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_command,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_run_length,
    input  logic [VAL_W-1:0]    i_relative_deadline,
    input  logic [VAL_W-1:0]    i_release_period,
    input  t_dp_cmd             i_cmd,
    input  logic [(TASK_SLOTS > 1 ? $clog2(TASK_SLOTS) : 1)-1:0] i_idx,
    output t_dp_stat            o_stat,
    output logic [TICK_W-1:0]   o_tick_time,
    output logic                o_busy_res,
    output logic [SLOT_W-1:0]   o_chosen_slot,
    output logic                o_job_done,
    output logic                o_late,
    output logic                o_backlog_full
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TB = TIME_BITS;
    localparam logic [TB-1:0] TOP = TB'(1) << (TB - 1);

    // task parameters and schedule state
    logic [VAL_W-1:0] r_job_len   [TASK_SLOTS];
    logic [VAL_W-1:0] r_dl_off    [TASK_SLOTS];
    logic [VAL_W-1:0] r_period    [TASK_SLOTS];
    logic [TB-1:0]    r_next_rel  [TASK_SLOTS];
    logic [BL_W-1:0]  r_backlog   [TASK_SLOTS];
    logic [VAL_W-1:0] r_head_left [TASK_SLOTS];
    logic [TB-1:0]    r_head_due  [TASK_SLOTS];
    logic [TB-1:0]    r_now;

    // captured item
    t_cmd             r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [VAL_W-1:0] r_run;
    logic [VAL_W-1:0] r_dl;
    logic [VAL_W-1:0] r_per;

    // best candidate so far
    logic             r_have;
    logic [IW-1:0]    r_pick;
    logic [TB-1:0]    r_best;
    logic [VAL_W-1:0] r_pk_left;
    logic [TB-1:0]    r_pk_due;
    logic [BL_W-1:0]  r_pk_bc;
    logic [VAL_W-1:0] r_pk_len;
    logic [VAL_W-1:0] r_pk_per;

    // result
    logic [TB-1:0]    r_time;
    logic             r_full;
    logic             r_busy;
    logic             r_done;
    logic             r_late;
    logic [TICK_W-1:0] r_o_time;
    logic             r_o_busy;
    logic [SLOT_W-1:0] r_o_slot;
    logic             r_o_done;
    logic             r_o_late;
    logic             r_o_full;

    logic [IW+SLOT_W-1:0]   w_slot_ext;
    logic [IW-1:0]          w_slot_idx;
    logic                   w_slot_ok;

    logic [VAL_W-1:0] w_jl;
    logic [VAL_W-1:0] w_doff;
    logic [VAL_W-1:0] w_per;
    logic [TB-1:0]    w_nr;
    logic [BL_W-1:0]  w_bc;
    logic [VAL_W-1:0] w_hl;
    logic [TB-1:0]    w_hd;
    logic             w_rel;
    logic             w_fresh;
    logic [TB-1:0]    w_nr_n;
    logic [BL_W-1:0]  w_bc_n;
    logic [VAL_W-1:0] w_hl_n;
    logic [TB-1:0]    w_hd_n;
    logic             w_full_hit;
    logic [TB-1:0]    w_dist;
    logic [TB-1:0]    w_key;
    logic             w_better;

    logic [VAL_W-1:0] w_left_m1;
    logic [BL_W-1:0]  w_bc_m1;
    logic             w_fin;
    logic [VAL_W-1:0] w_ap_left;
    logic [BL_W-1:0]  w_ap_bc;
    logic [TB-1:0]    w_ap_due;
    logic [TB-1:0]    w_late_diff;
    logic             w_late;

    logic [TB+TICK_W-1:0]   w_time_ext;
    logic [IW+SLOT_W-1:0]   w_pick_ext;
    logic                   w_is_tick;

    assign w_slot_ext = {{IW{1'b0}}, r_slot};
    assign w_slot_idx = w_slot_ext[IW-1:0];
    assign w_slot_ok  = (32'(r_slot) < 32'(TASK_SLOTS));

    // release and candidate test for the slot under scan
    always_comb begin
        w_jl   = r_job_len[i_idx];
        w_doff = r_dl_off[i_idx];
        w_per  = r_period[i_idx];
        w_nr   = r_next_rel[i_idx];
        w_bc   = r_backlog[i_idx];
        w_hl   = r_head_left[i_idx];
        w_hd   = r_head_due[i_idx];

        w_rel      = (w_nr == r_now);
        w_nr_n     = w_rel ? (w_nr + TB'(w_per)) : w_nr;
        w_fresh    = w_rel && (w_jl != '0) && (w_bc == '0);
        w_bc_n     = w_bc;
        w_hl_n     = w_hl;
        w_hd_n     = w_hd;
        w_full_hit = 1'b0;
        if (w_rel && (w_jl != '0)) begin
            if (w_bc == '0) begin
                w_hl_n = w_jl;
                w_hd_n = r_now + TB'(w_doff);
                w_bc_n = BL_W'(1);
            end else if (w_bc == BL_MAX) begin
                w_full_hit = 1'b1;
            end else begin
                w_bc_n = w_bc + BL_W'(1);
            end
        end

        // a fresh head sits exactly its deadline offset ahead of now
        w_dist   = w_fresh ? TB'(w_doff) : (w_hd - r_now);
        w_key    = w_dist ^ TOP;
        w_better = (w_bc_n != '0) && (w_hl_n != '0) && (!r_have || (w_key < r_best));
    end

    // one unit of work on the picked head
    always_comb begin
        w_left_m1 = r_pk_left - VAL_W'(1);
        w_bc_m1   = r_pk_bc - BL_W'(1);
        w_fin     = (w_left_m1 == '0);
        w_ap_left = w_left_m1;
        w_ap_bc   = r_pk_bc;
        w_ap_due  = r_pk_due;
        if (w_fin) begin
            w_ap_bc = w_bc_m1;
            if (w_bc_m1 != '0) begin
                if (r_pk_len == '0) begin
                    w_ap_bc = '0;
                end else begin
                    w_ap_left = r_pk_len;
                    w_ap_due  = r_pk_due + TB'(r_pk_per);
                end
            end
        end
        w_late_diff = r_now + TB'(1) - r_pk_due;
        w_late = w_fin && (w_late_diff != '0) && !w_late_diff[TB-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_job_len[k]   <= '0;
                r_dl_off[k]    <= '0;
                r_period[k]    <= '0;
                r_next_rel[k]  <= '0;
                r_backlog[k]   <= '0;
                r_head_left[k] <= '0;
                r_head_due[k]  <= '0;
            end
            r_now <= '0;
        end else begin
            if (i_cmd.load && w_slot_ok) begin
                r_job_len[w_slot_idx] <= r_run;
                r_dl_off[w_slot_idx]  <= r_dl;
                r_period[w_slot_idx]  <= r_per;
            end
            if (i_cmd.restart) begin
                for (int k = 0; k < TASK_SLOTS; k++) begin
                    r_next_rel[k]  <= '0;
                    r_backlog[k]   <= '0;
                    r_head_left[k] <= '0;
                    r_head_due[k]  <= '0;
                end
                r_now <= '0;
            end
            if (i_cmd.scan) begin
                r_next_rel[i_idx]  <= w_nr_n;
                r_backlog[i_idx]   <= w_bc_n;
                r_head_left[i_idx] <= w_hl_n;
                r_head_due[i_idx]  <= w_hd_n;
            end
            if (i_cmd.apply) begin
                if (r_have) begin
                    r_head_left[r_pick] <= w_ap_left;
                    r_backlog[r_pick]   <= w_ap_bc;
                    r_head_due[r_pick]  <= w_ap_due;
                end
                r_now <= r_now + TB'(1);
            end
        end
    end

    assign w_time_ext = {{TICK_W{1'b0}}, r_time};
    assign w_pick_ext = {{SLOT_W{1'b0}}, r_pick};
    assign w_is_tick  = (r_cmd == CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_slot <= i_slot;
            r_run  <= i_run_length;
            r_dl   <= i_relative_deadline;
            r_per  <= i_release_period;
        end
        if (i_cmd.start) begin
            r_have <= 1'b0;
            r_pick <= '0;
            r_full <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_late <= 1'b0;
            r_time <= r_now;
        end
        if (i_cmd.scan) begin
            if (w_full_hit) begin
                r_full <= 1'b1;
            end
            if (w_better) begin
                r_have    <= 1'b1;
                r_pick    <= i_idx;
                r_best    <= w_key;
                r_pk_left <= w_hl_n;
                r_pk_due  <= w_hd_n;
                r_pk_bc   <= w_bc_n;
                r_pk_len  <= w_jl;
                r_pk_per  <= w_per;
            end
        end
        if (i_cmd.apply) begin
            r_busy <= r_have;
            r_done <= r_have && w_fin;
            r_late <= r_have && w_late;
        end
        if (i_cmd.publish) begin
            r_o_time <= w_is_tick ? w_time_ext[TICK_W-1:0] : '0;
            r_o_busy <= w_is_tick && r_busy;
            r_o_slot <= (w_is_tick && r_have) ? w_pick_ext[SLOT_W-1:0] : '0;
            r_o_done <= w_is_tick && r_done;
            r_o_late <= w_is_tick && r_late;
            r_o_full <= w_is_tick && r_full;
        end
    end

    assign o_stat.item_cmd = r_cmd;
    assign o_tick_time     = r_o_time;
    assign o_busy_res      = r_o_busy;
    assign o_chosen_slot   = r_o_slot;
    assign o_job_done      = r_o_done;
    assign o_late          = r_o_late;
    assign o_backlog_full  = r_o_full;

endmodule

@@ rtl/core/edf_tick_scheduler.sv @@
// edf_tick_scheduler: top level of the per-tick earliest-deadline-first scheduler
// joins the controller and the datapath
// depends on edf_pkg, edf_ctrl, edf_dpath
//
// usage
// input channel i_in_valid / o_in_stall carries one command item: load task
// parameters into a slot, restart the schedule, or execute one time tick.
// output channel o_out_valid / i_out_stall returns one result item per command;
// load, restart and unused codes return an all-zero item.
// configuration channel i_cfg_valid / o_cfg_ready writes the active slot count;
// it is always ready.
// a tick is decoded, then scans the first n slots, n being the active slot count
// capped at TASK_SLOTS: the slots are released and compared one per cycle through
// a single compare unit, then the picked slot is updated and the result is
// published from the finish state. load and restart go from decode straight to
// finish; restart clears all schedule state in the decode state.
// the result sits in an output register, so the next item is taken while the
// previous result waits; a stalled receiver holds the block before it writes
// the following result. synchronous reset clears all tables, time and the count
// (to one active slot).
module edf_tick_scheduler
    import edf_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_run_length,
    input  logic [VAL_W-1:0]    i_relative_deadline,
    input  logic [VAL_W-1:0]    i_release_period,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TICK_W-1:0]   o_tick_time,
    output logic                o_busy_res,
    output logic [SLOT_W-1:0]   o_chosen_slot,
    output logic                o_job_done,
    output logic                o_late,
    output logic                o_backlog_full,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ACT_W-1:0]    i_cfg_data
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    t_dp_cmd        w_cmd;
    t_dp_stat       w_stat;
    logic [IW-1:0]  w_idx;

    edf_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    edf_dpath #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_command           (i_command),
        .i_slot              (i_slot),
        .i_run_length        (i_run_length),
        .i_relative_deadline (i_relative_deadline),
        .i_release_period    (i_release_period),
        .i_cmd               (w_cmd),
        .i_idx               (w_idx),
        .o_stat              (w_stat),
        .o_tick_time         (o_tick_time),
        .o_busy_res          (o_busy_res),
        .o_chosen_slot       (o_chosen_slot),
        .o_job_done          (o_job_done),
        .o_late              (o_late),
        .o_backlog_full      (o_backlog_full)
    );

    assign o_cfg_ready = 1'b1;

endmodule

@@ rtl/core/edf_checker.sv @@
// edf_checker: port-level assertions for the edf tick scheduler
// bound to edf_tick_scheduler; depends on edf_pkg
module edf_checker
    import edf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_run_length,
    input  logic [VAL_W-1:0]    i_relative_deadline,
    input  logic [VAL_W-1:0]    i_release_period,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [TICK_W-1:0]   o_tick_time,
    input  logic                o_busy_res,
    input  logic [SLOT_W-1:0]   o_chosen_slot,
    input  logic                o_job_done,
    input  logic                o_late,
    input  logic                o_backlog_full,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic [ACT_W-1:0]    i_cfg_data
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tick_time)
            && $stable(o_chosen_slot) && $stable(o_busy_res) && $stable(o_late))
        else $error("result changed while stalled");

    // one item in work at a time
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous one in work");

    // after reset nothing pending and input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // idle tick reports slot zero and no completion
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_chosen_slot == '0 && !o_job_done && !o_late)
        else $error("idle result carries job fields");

    // lateness only on a completed job
    a_late_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_late |-> o_job_done && o_busy_res)
        else $error("late flag without completion");

endmodule

bind edf_tick_scheduler edf_checker u_edf_checker (.*);
